FILE: hdl/chm_pkg.sv
// shared types and codes for the chained hash map
`timescale 1ns / 1ps
package chm_pkg;
    localparam int unsigned BUCKETS_DEF = 256;
    localparam int unsigned SLOTS_DEF = 8;
    localparam int unsigned KEY_W = 32;
    localparam int unsigned VAL_W = 32;
    localparam int unsigned TOTAL_W = 12;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_FOUND  = 2'd0,
        ST_ABSENT = 2'd1,
        ST_NEW    = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture input beat, start reciprocal multiply
        logic hash;     // finish bucket index
        logic fetch;    // read bucket row and fill count
        logic compare;  // row data valid, evaluate
        logic commit;   // write back and form result
    } chm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_busy;
    } chm_stat_t;
endpackage

FILE: hdl/chm_ctrl.sv
// controller state machine for the chained hash map
`timescale 1ns / 1ps
module chm_ctrl
    import chm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  chm_stat_t stat,
    output chm_cmd_t  cmd
);
    typedef enum logic [2:0] {S_IDLE, S_HASH, S_READ, S_EVAL, S_OUT} state_t;

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;

    // accept only when result slot is free or leaving
    assign s_tready = (state_reg == S_IDLE) && !stat.clear_busy
                      && (!mvalid_reg || m_tready);
    assign m_tvalid = mvalid_reg;

    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg;
        cmd         = '0;
        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.load   = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                cmd.hash   = 1'b1;
                state_next = S_READ;
            end
            S_READ: begin
                cmd.fetch  = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                cmd.compare = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT: begin
                cmd.commit  = 1'b1;
                mvalid_next = 1'b1;
                state_next  = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end
endmodule

FILE: hdl/chm_dp.sv
// datapath: bucket fill table, key/value row memories, slot compare
`timescale 1ns / 1ps
module chm_dp
    import chm_pkg::*;
#(
    parameter int unsigned BUCKETS = BUCKETS_DEF,
    parameter int unsigned SLOTS_PER_BUCKET = SLOTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  chm_cmd_t           cmd,
    output chm_stat_t          stat,
    input  logic [1:0]         in_kind,
    input  logic [KEY_W-1:0]   in_key,
    input  logic [VAL_W-1:0]   in_value,
    output logic [1:0]         out_status,
    output logic [VAL_W-1:0]   out_found_value,
    output logic [TOTAL_W-1:0] out_entry_total
);
    localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int unsigned SW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int unsigned FW = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int unsigned S = SLOTS_PER_BUCKET;
    localparam logic [FW-1:0] FULL = FW'(SLOTS_PER_BUCKET);
    localparam int unsigned HL = $clog2(BUCKETS);
    // ceil(2^(32+HL) / BUCKETS): quotient is exact for every 32-bit key
    localparam logic [32:0] RECIP =
        33'(((64'd1 << (32 + HL)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

    // one row per bucket, all slots side by side
    logic [S*KEY_W-1:0] key_mem [BUCKETS];
    logic [S*VAL_W-1:0] val_mem [BUCKETS];
    logic [FW-1:0]      fill_mem [BUCKETS];

    logic [1:0]         kind_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VAL_W-1:0]   value_reg;
    logic [BW-1:0]      bkt_reg;
    logic [S*KEY_W-1:0] krow_reg;
    logic [S*VAL_W-1:0] vrow_reg;
    logic [FW-1:0]      fill_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               hit_reg;
    logic [SW-1:0]      slot_reg;
    logic [1:0]         status_reg;
    logic [VAL_W-1:0]   found_reg;
    logic               clr_busy_reg;
    logic [BW-1:0]      clr_idx_reg;
    logic [KEY_W+32:0]  prod_reg;
    logic [KEY_W-1:0]   quot_c;
    logic [KEY_W-1:0]   qb_c;
    logic [KEY_W-1:0]   rem_c;

    // key mod BUCKETS by reciprocal multiply; the remainder is formed from the registered product
    assign quot_c = KEY_W'(prod_reg >> (32 + HL));
    assign qb_c   = quot_c * KEY_W'(BUCKETS);
    assign rem_c  = key_reg - qb_c;

    logic [S-1:0] match;
    logic         hit_c;
    logic [SW-1:0] slot_c;
    always_comb begin
        hit_c  = 1'b0;
        slot_c = '0;
        for (int i = 0; i < S; i++) begin
            match[i] = (krow_reg[i*KEY_W +: KEY_W] == key_reg) && (FW'(i) < fill_reg);
        end
        for (int i = S - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_c  = 1'b1;
                slot_c = SW'(i);
            end
        end
    end

    logic [SW-1:0] last_c;
    assign last_c = SW'(fill_reg - FW'(1));

    function automatic logic in_kind_ok();
        return (kind_reg == KIND_INSERT && (hit_reg || fill_reg != FULL))
            || (kind_reg == KIND_REMOVE && hit_reg);
    endfunction

    function automatic logic [S*KEY_W-1:0] krow_upd();
        logic [S*KEY_W-1:0] r;
        r = krow_reg;
        if (kind_reg == KIND_INSERT && !hit_reg) begin
            r[SW'(fill_reg)*KEY_W +: KEY_W] = key_reg;
        end else if (kind_reg == KIND_REMOVE) begin
            r[slot_reg*KEY_W +: KEY_W] = krow_reg[last_c*KEY_W +: KEY_W];
        end
        return r;
    endfunction

    function automatic logic [S*VAL_W-1:0] vrow_upd();
        logic [S*VAL_W-1:0] r;
        r = vrow_reg;
        if (kind_reg == KIND_INSERT) begin
            r[(hit_reg ? slot_reg : SW'(fill_reg))*VAL_W +: VAL_W] = value_reg;
        end else if (kind_reg == KIND_REMOVE) begin
            r[slot_reg*VAL_W +: VAL_W] = vrow_reg[last_c*VAL_W +: VAL_W];
        end
        return r;
    endfunction

    // memory reads and writes
    always_ff @(posedge aclk) begin
        if (cmd.fetch) begin
            krow_reg <= key_mem[bkt_reg];
            vrow_reg <= val_mem[bkt_reg];
        end
        if (cmd.commit && in_kind_ok()) begin
            key_mem[bkt_reg] <= krow_upd();
            val_mem[bkt_reg] <= vrow_upd();
        end
    end

    // fill table: registered read, cleared by a sweep
    always_ff @(posedge aclk) begin
        if (cmd.fetch) begin
            fill_reg <= fill_mem[bkt_reg];
        end
        if (clr_busy_reg) begin
            fill_mem[clr_idx_reg] <= '0;
        end else if (cmd.commit && in_kind_ok()) begin
            fill_mem[bkt_reg] <= (kind_reg == KIND_INSERT)
                ? (hit_reg ? fill_reg : fill_reg + FW'(1)) : fill_reg - FW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg  <= in_kind;
            key_reg   <= in_key;
            value_reg <= in_value;
            prod_reg  <= {33'd0, in_key} * {32'd0, RECIP};
        end
        if (cmd.hash) begin
            bkt_reg <= BW'(rem_c);
        end
        if (cmd.compare) begin
            hit_reg  <= hit_c;
            slot_reg <= slot_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg    <= '0;
            status_reg   <= ST_FOUND;
            found_reg    <= '0;
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end else begin
            if (clr_busy_reg) begin
                clr_idx_reg <= clr_idx_reg + BW'(1);
                if (clr_idx_reg == BW'(BUCKETS - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end else if (cmd.commit) begin
                case (kind_reg)
                    KIND_CLEAR: begin
                        found_reg    <= '0;
                        status_reg   <= ST_FOUND;
                        total_reg    <= '0;
                        clr_busy_reg <= 1'b1;
                        clr_idx_reg  <= '0;
                    end
                    KIND_LOOKUP: begin
                        status_reg <= hit_reg ? ST_FOUND : ST_ABSENT;
                        found_reg  <= hit_reg ? vrow_reg[slot_reg*VAL_W +: VAL_W] : '0;
                    end
                    KIND_INSERT: begin
                        found_reg <= '0;
                        if (hit_reg) begin
                            status_reg <= ST_FOUND;
                        end else if (fill_reg == FULL) begin
                            status_reg <= ST_FULL;
                        end else begin
                            status_reg <= ST_NEW;
                            total_reg  <= total_reg + TOTAL_W'(1);
                        end
                    end
                    default: begin
                        found_reg  <= '0;
                        status_reg <= hit_reg ? ST_FOUND : ST_ABSENT;
                        if (hit_reg) total_reg <= total_reg - TOTAL_W'(1);
                    end
                endcase
            end
        end
    end

    assign stat.clear_busy = clr_busy_reg;
    assign out_status      = status_reg;
    assign out_found_value = found_reg;
    assign out_entry_total = total_reg;
endmodule

FILE: hdl/chained_hash_map_u32.sv
// top level of the chained hash map
//  channel | dir | tdata fields (low bit up)                 | tuser
//  s_      | in  | kind[1:0] key[33:2] value[65:34], pad 72  | -
//  m_      | out | status[1:0] found_value[33:2] total[45:34], pad 48 | -
// a result goes valid after its beat passes reciprocal multiply, bucket
// index, row read, slot compare, then write back and result
// no new beat is taken until the previous one has passed write back
// after reset and after every clear, the fill table is swept one bucket a
// cycle while s_tready stays low
// a waiting result holds s_tready low until it is taken
`timescale 1ns / 1ps
module chained_hash_map_u32
    import chm_pkg::*;
#(
    parameter int unsigned BUCKETS = BUCKETS_DEF,
    parameter int unsigned SLOTS_PER_BUCKET = SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // kind, key, value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status, found_value, entry_total
);
    chm_cmd_t  cmd;
    chm_stat_t stat;
    logic [1:0]         st;
    logic [VAL_W-1:0]   fv;
    logic [TOTAL_W-1:0] tot;

    // control sequencing
    chm_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready,
        .stat, .cmd
    );

    // storage and compare
    chm_dp #(.BUCKETS(BUCKETS), .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET)) u_dp (
        .aclk, .aresetn, .cmd, .stat,
        .in_kind(s_tdata[1:0]), .in_key(s_tdata[33:2]), .in_value(s_tdata[65:34]),
        .out_status(st), .out_found_value(fv), .out_entry_total(tot)
    );

    assign m_tdata = {2'b00, tot, fv, st};

`ifndef SYNTH
    // no beat accepted during the fill sweep
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.clear_busy |-> !s_tready) else $error("accept during clear");
    // found_value nonzero only with found status
    a_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != ST_FOUND |-> m_tdata[33:2] == '0)
        else $error("value on miss");
    // commit raises the output valid
    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid) else $error("lost result");
`endif
endmodule

FILE: tb/sv/chained_hash_map_u32_checker.sv
// result checker for the chained hash map: tracks the table and compares every result beat
`timescale 1ns / 1ps
module chained_hash_map_u32_checker
    import chm_pkg::*;
#(
    parameter int unsigned BUCKETS = BUCKETS_DEF,
    parameter int unsigned SLOTS_PER_BUCKET = SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    output int          fail_count,
    output int          pending_count
);
    typedef struct packed {
        status_t            status;
        logic [VAL_W-1:0]   found_value;
        logic [TOTAL_W-1:0] entry_total;
    } map_result_t;

    logic [KEY_W-1:0] keys [BUCKETS][SLOTS_PER_BUCKET];
    logic [VAL_W-1:0] vals [BUCKETS][SLOTS_PER_BUCKET];
    int unsigned      fill [BUCKETS];
    int unsigned      held;
    map_result_t      awaited [$];

    assign pending_count = awaited.size();

    // apply one operation to the shadow table and return its result
    function automatic map_result_t apply_op(kind_t kind, logic [KEY_W-1:0] key,
                                             logic [VAL_W-1:0] value);
        map_result_t r;
        int unsigned b;
        int unsigned n;
        int          hit;
        r = '{status: ST_ABSENT, found_value: '0, entry_total: '0};
        if (kind == KIND_CLEAR) begin
            foreach (fill[i]) fill[i] = 0;
            held = 0;
            r.status = ST_FOUND;
        end else begin
            b = key % BUCKETS;
            n = fill[b];
            hit = -1;
            for (int s = 0; s < n; s++)
                if (hit < 0 && keys[b][s] == key) hit = s;
            case (kind)
                KIND_LOOKUP: begin
                    if (hit >= 0) begin
                        r.status = ST_FOUND;
                        r.found_value = vals[b][hit];
                    end
                end
                KIND_INSERT: begin
                    if (hit >= 0) begin
                        vals[b][hit] = value;
                        r.status = ST_FOUND;
                    end else if (n >= SLOTS_PER_BUCKET) begin
                        r.status = ST_FULL;
                    end else begin
                        keys[b][n] = key;
                        vals[b][n] = value;
                        fill[b] = n + 1;
                        held++;
                        r.status = ST_NEW;
                    end
                end
                default: begin
                    if (hit >= 0) begin
                        // last entry of the bucket fills the hole
                        keys[b][hit] = keys[b][n-1];
                        vals[b][hit] = vals[b][n-1];
                        fill[b] = n - 1;
                        if (held > 0) held--;
                        r.status = ST_FOUND;
                    end
                end
            endcase
        end
        r.entry_total = held[TOTAL_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        map_result_t want;
        map_result_t got;
        if (!aresetn) begin
            foreach (fill[i]) fill[i] = 0;
            held = 0;
            awaited.delete();
            fail_count <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{status: status_t'(m_tdata[1:0]), found_value: m_tdata[33:2],
                        entry_total: m_tdata[45:34]};
                if (awaited.size() == 0) begin
                    $error("result beat with nothing awaited: %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = awaited.pop_front();
                    if (got != want) begin
                        if (got.status != want.status)
                            $error("status expected %0d actual %0d", want.status, got.status);
                        if (got.found_value != want.found_value)
                            $error("found_value expected %h actual %h",
                                   want.found_value, got.found_value);
                        if (got.entry_total != want.entry_total)
                            $error("entry_total expected %0d actual %0d",
                                   want.entry_total, got.entry_total);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                awaited.push_back(apply_op(kind_t'(s_tdata[1:0]), s_tdata[33:2],
                                           s_tdata[65:34]));
        end
    end
endmodule

FILE: tb/sv/chained_hash_map_u32_test.sv
// stimulus and verdict for the chained hash map
`timescale 1ns / 1ps
module chained_hash_map_u32_test;
    import chm_pkg::*;

    localparam int unsigned BUCKETS = BUCKETS_DEF;
    localparam int unsigned SLOTS = SLOTS_DEF;
    localparam int RANDOM_OPS = 930;
    localparam longint CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;   // kind[1:0] key[33:2] value[65:34], zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // status[1:0] found_value[33:2] entry_total[45:34], pad
    int          fail_count;
    int          pending_count;
    longint      cycles = 0;
    bit          long_hold = 1'b0;
    int          clears = 0;
    int          fills = 0;

    // small key pool so that hits, replaces and removes are common
    logic [31:0] key_pool [16];

    chained_hash_map_u32 #(.BUCKETS(BUCKETS), .SLOTS_PER_BUCKET(SLOTS)) dut (.*);

    chained_hash_map_u32_checker #(.BUCKETS(BUCKETS), .SLOTS_PER_BUCKET(SLOTS)) checker_i (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .fail_count, .pending_count
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: own stall pattern, plus one long hold-off on request
    initial begin
        int phase;
        int stall_len;
        phase = 0;
        @(posedge aclk);
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                long_hold = 1'b0;
            end
            phase++;
            if ((phase / 64) % 3 == 0)
                m_tready <= 1'b1;          // stretch with no stalls
            else begin
                stall_len = $urandom_range(0, 3);
                m_tready <= (stall_len == 0);
            end
            @(posedge aclk);
        end
    end

    // offer one beat and hold it until accepted
    task automatic send_op(kind_t kind, logic [31:0] key, logic [31:0] value);
        s_tdata <= {6'd0, value, key, kind};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (kind == KIND_CLEAR) clears++;
    endtask

    task automatic go_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return {19'd0, 5'($urandom_range(0, 31)), 8'd7};  // pile up in one bucket
            default: return key_pool[$urandom_range(0, 15)];
        endcase
    endfunction

    initial begin
        int burst;
        int sel;
        kind_t kind;
        foreach (key_pool[i]) key_pool[i] = $urandom();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, every kind, full bucket, replace, removes
        send_op(KIND_LOOKUP, 32'h0, 32'hFFFF_FFFF);              // miss on empty table
        send_op(KIND_REMOVE, 32'hFFFF_FFFF, 32'h0);              // remove absent
        send_op(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(KIND_INSERT, 32'h0, 32'h0);
        send_op(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0);              // hit
        send_op(KIND_INSERT, 32'hFFFF_FFFF, 32'h1234_5678);      // replace
        send_op(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        for (int i = 1; i <= 9; i++)                             // bucket zero overfills
            send_op(KIND_INSERT, i << 8, ~(i << 8));
        send_op(KIND_REMOVE, 32'h100, 32'h0);                    // middle slot, last moves in
        send_op(KIND_LOOKUP, 32'h800, 32'h0);
        send_op(KIND_REMOVE, 32'h800, 32'h0);                    // absent: its insert found the bucket full
        send_op(KIND_LOOKUP, 32'h700, 32'h0);
        send_op(KIND_CLEAR, 32'hAAAA_5555, 32'h5555_AAAA);
        send_op(KIND_LOOKUP, 32'h0, 32'h0);
        go_idle();

        // sender pauses until every result is in
        while (pending_count != 0) @(posedge aclk);

        // fill the table from many buckets while the receiver holds off
        long_hold = 1'b1;
        for (int i = 0; i < 40; i++)
            send_op(KIND_INSERT, $urandom(), $urandom());

        for (int n = 0; n < RANDOM_OPS; ) begin
            burst = $urandom_range(1, 24);
            for (int j = 0; j < burst && n < RANDOM_OPS; j++, n++) begin
                sel = $urandom_range(0, 99);
                if (sel < 1) kind = KIND_CLEAR;
                else if (sel < 40) kind = KIND_INSERT;
                else if (sel < 70) kind = KIND_LOOKUP;
                else kind = KIND_REMOVE;
                if (kind == KIND_INSERT && {28'd0, 4'(fills)} == 0) fills++;
                send_op(kind, pick_key(), $urandom());
            end
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(posedge aclk);
        end
        go_idle();

        while (pending_count != 0) @(posedge aclk);
        repeat (BUCKETS + 20) @(posedge aclk);

        $display("ran %0d operations: lookups, inserts, replaces, removes, full buckets,",
                 RANDOM_OPS + 62);
        $display("%0d table clears, with random gaps and receiver stalls", clears);
        if (fail_count == 0 && pending_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
